### rtl/assert_macros.svh
// Assertion macros used by the RTL module of the gear shift sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every rising clock edge, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/psq_pkg.sv
// Types, codes and constants of the paddle gear shift sequencer.
`default_nettype none
package psq_pkg;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_PADDLE = 2'd1,
		OP_FRAME  = 2'd2
	} opcode_t;

	// Input request payload
	typedef struct packed {
		logic [1:0]  opcode;
		logic        up_fell;
		logic        up_changed;
		logic        down_fell;
		logic        down_changed;
		logic [10:0] frame_id;
		logic [63:0] frame_data;
	} in_item_t;

	// Result request payload
	typedef struct packed {
		logic       motor_pulse;
		logic       motor_dir;
		logic       busy_res;
		logic       done_res;
		logic       rejected;
		logic [7:0] gear_now;
	} out_item_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RPM_LIMIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_TICKS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TICKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_GEAR      = 3'd5;

	// Register reset values
	localparam logic [15:0] RPM_LIMIT_RST     = 16'd5000;
	localparam logic [7:0]  UP_TICKS_RST      = 8'd100;
	localparam logic [7:0]  DOWN_TICKS_RST    = 8'd100;
	localparam logic [7:0]  NEUTRAL_TICKS_RST = 8'd30;
	localparam logic [2:0]  MAX_TRIES_RST     = 3'd3;
	localparam logic [3:0]  TOP_GEAR_RST      = 4'd6;

	// Bus frame identifiers
	localparam logic [10:0] ID_SPEED = 11'd1520;
	localparam logic [10:0] ID_GEAR  = 11'd1553;

	// Gears that the neutral search treats specially
	localparam logic [7:0] GEAR_FIRST  = 8'd1;
	localparam logic [7:0] GEAR_SECOND = 8'd2;

	// Shift phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PULSE = 3'b010,
		PH_HALF  = 3'b100
	} phase_t;

	// Kind of the request in progress
	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_UP      = 2'd1,
		KIND_DOWN    = 2'd2,
		KIND_NEUTRAL = 2'd3
	} kind_t;

	// Outcome of one step of the sequencer
	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_OK   = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	localparam logic       DIR_UP   = 1'b1;
	localparam logic       DIR_DOWN = 1'b0;
	localparam logic [2:0] TRIES_FIRST = 3'd1;

endpackage
`default_nettype wire

### rtl/paddle_gear_shift_sequencer.sv
// Top level of the paddle gear shift sequencer: input stage, shift control, result stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_stall  | in_req  (tick, paddle event, frame)
//   result   | out_valid / out_stall| out_req (motor drive, status, gear)
//   config   | cfg_we               | cfg_index, cfg_data
//
// Each request is held in the input register and is then resolved in one
// pass of the shift control logic into the result register, at one request per
// cycle while out_stall is low. The input register takes a new request while a
// result waits under out_stall; in_stall rises only when both stages are full.
// Reset (arst_n low) returns the registers to their defaults and the sequencer to idle.
`default_nettype none
`include "assert_macros.svh"
module paddle_gear_shift_sequencer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  psq_pkg::in_item_t                     in_req,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output psq_pkg::out_item_t                    out_req,
	input  wire                                   cfg_we,
	input  wire  [psq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [psq_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import psq_pkg::*;

	// Sequencer state that one step rewrites
	typedef struct packed {
		phase_t     phase;
		kind_t      kind;
		logic [7:0] timer;
		logic [2:0] tries;
		logic [7:0] gstart;
		logic       dir;
	} seq_state_t;

	typedef struct packed {
		seq_state_t s;
		status_t    st;
	} step_t;

	typedef struct packed {
		logic [15:0] rpm_limit;
		logic [7:0]  up_ticks;
		logic [7:0]  down_ticks;
		logic [7:0]  neutral_ticks;
		logic [2:0]  max_tries;
		logic [3:0]  top_gear;
	} cfg_t;

	cfg_t        cfg_q;
	seq_state_t  state_q;
	logic [7:0]  gear_q;
	logic [15:0] speed_q;

	in_item_t    in_req_s1;
	logic        in_valid_s1;
	out_item_t   res_s2;
	logic        res_valid_s2;

	logic        advance;
	seq_state_t  state_d;
	logic [7:0]  gear_d;
	logic [15:0] speed_d;
	logic        done;
	logic        rej;
	step_t       step;

	// ---- step helpers ----
	function automatic seq_state_t load_pulse(seq_state_t s, logic [7:0] ticks, logic dir,
			phase_t ph);
		seq_state_t r;
		r = s;
		r.timer = (ticks == 8'd0) ? 8'd1 : ticks;
		r.dir = dir;
		r.phase = ph;
		return r;
	endfunction

	function automatic step_t begin_up(seq_state_t s, logic [7:0] gear, cfg_t c);
		step_t r;
		r.s = s;
		r.s.gstart = gear;
		r.s = load_pulse(r.s, c.up_ticks, DIR_UP, PH_PULSE);
		r.st = ST_RUN;
		return r;
	endfunction

	function automatic step_t begin_down(seq_state_t s, logic [7:0] gear, logic [15:0] speed,
			cfg_t c);
		step_t r;
		r.s = s;
		r.s.gstart = gear;
		r.st = ST_RUN;
		// downshift at speed is refused
		if (speed >= c.rpm_limit) begin
			r.st = ST_FAIL;
		end else begin
			r.s = load_pulse(r.s, c.down_ticks, DIR_DOWN, PH_PULSE);
		end
		return r;
	endfunction

	function automatic step_t begin_neutral(seq_state_t s, logic [7:0] gear, logic [15:0] speed,
			cfg_t c);
		step_t r;
		r.s = s;
		r.st = ST_RUN;
		if (gear > GEAR_SECOND) begin
			r = begin_down(s, gear, speed, c);
		end else begin
			r.s.gstart = gear;
			if (gear == GEAR_SECOND) begin
				r.s = load_pulse(r.s, c.neutral_ticks, DIR_DOWN, PH_HALF);
			end else if (gear == GEAR_FIRST) begin
				r.s = load_pulse(r.s, c.neutral_ticks, DIR_UP, PH_HALF);
			end else begin
				r.st = ST_OK;
			end
		end
		return r;
	endfunction

	function automatic step_t pulse_ended(seq_state_t s, logic [7:0] gear, logic [15:0] speed,
			cfg_t c);
		step_t r;
		logic  half;
		half = (s.phase == PH_HALF);
		r.s = s;
		r.s.phase = PH_IDLE;
		r.st = ST_FAIL;
		if (gear != s.gstart) begin
			// gear moved: neutral keeps stepping until the half pulse is done
			if (s.kind == KIND_NEUTRAL && !half) begin
				r = begin_neutral(r.s, gear, speed, c);
			end else begin
				r.st = ST_OK;
			end
		end else if (s.gstart == {4'd0, c.top_gear}) begin
			r.st = ST_FAIL;
		end else if (s.tries < c.max_tries) begin
			// retry the same kind of step
			r.s.tries = s.tries + 3'd1;
			case (s.kind)
				KIND_UP:   r = begin_up(r.s, gear, c);
				KIND_DOWN: r = begin_down(r.s, gear, speed, c);
				default:   r = begin_neutral(r.s, gear, speed, c);
			endcase
		end
		return r;
	endfunction

	// ---- pipeline control ----
	assign advance  = in_valid_s1 && (!res_valid_s2 || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_req_s1 <= in_req;
		end
	end

	// ---- one pass of the shift control ----
	always_comb begin
		logic active;
		active  = 1'b0;
		state_d = state_q;
		gear_d  = gear_q;
		speed_d = speed_q;
		step.s  = state_q;
		step.st = ST_RUN;
		case (opcode_t'(in_req_s1.opcode))
			OP_TICK: begin
				if (state_q.phase != PH_IDLE) begin
					active = 1'b1;
					if (step.s.timer != 8'd0) begin
						step.s.timer = step.s.timer - 8'd1;
					end
					if (step.s.timer == 8'd0) begin
						step = pulse_ended(step.s, gear_q, speed_q, cfg_q);
					end
				end
			end
			OP_PADDLE: begin
				if (state_q.phase == PH_IDLE &&
						(in_req_s1.up_changed || in_req_s1.down_changed)) begin
					step.s.tries = TRIES_FIRST;
					if (in_req_s1.up_fell && in_req_s1.down_fell) begin
						active = 1'b1;
						step.s.kind = KIND_NEUTRAL;
						step = begin_neutral(step.s, gear_q, speed_q, cfg_q);
					end else if (in_req_s1.up_fell && !in_req_s1.down_changed) begin
						active = 1'b1;
						step.s.kind = KIND_UP;
						step = begin_up(step.s, gear_q, cfg_q);
					end else if (!in_req_s1.up_changed && in_req_s1.down_fell) begin
						active = 1'b1;
						step.s.kind = KIND_DOWN;
						step = begin_down(step.s, gear_q, speed_q, cfg_q);
					end
				end
			end
			OP_FRAME: begin
				if (in_req_s1.frame_id == ID_SPEED) begin
					speed_d = in_req_s1.frame_data[15:0];
				end else if (in_req_s1.frame_id == ID_GEAR) begin
					gear_d = in_req_s1.frame_data[15:8];
				end
			end
			default: begin
			end
		endcase
		done = active && (step.st != ST_RUN);
		rej  = done && (step.st == ST_FAIL);
		state_d = step.s;
		// a finished request returns to idle
		if (done) begin
			state_d.phase = PH_IDLE;
			state_d.kind  = KIND_NONE;
			state_d.timer = 8'd0;
			state_d.tries = TRIES_FIRST;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase  <= PH_IDLE;
			state_q.kind   <= KIND_NONE;
			state_q.timer  <= 8'd0;
			state_q.tries  <= TRIES_FIRST;
			state_q.gstart <= 8'd0;
			state_q.dir    <= DIR_DOWN;
			gear_q         <= 8'd0;
			speed_q        <= 16'd0;
		end else if (advance) begin
			state_q <= state_d;
			gear_q  <= gear_d;
			speed_q <= speed_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_limit     <= RPM_LIMIT_RST;
			cfg_q.up_ticks      <= UP_TICKS_RST;
			cfg_q.down_ticks    <= DOWN_TICKS_RST;
			cfg_q.neutral_ticks <= NEUTRAL_TICKS_RST;
			cfg_q.max_tries     <= MAX_TRIES_RST;
			cfg_q.top_gear      <= TOP_GEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RPM_LIMIT:     cfg_q.rpm_limit     <= cfg_data;
				CFG_UP_TICKS:      cfg_q.up_ticks      <= cfg_data[7:0];
				CFG_DOWN_TICKS:    cfg_q.down_ticks    <= cfg_data[7:0];
				CFG_NEUTRAL_TICKS: cfg_q.neutral_ticks <= cfg_data[7:0];
				CFG_MAX_TRIES:     cfg_q.max_tries     <= cfg_data[2:0];
				CFG_TOP_GEAR:      cfg_q.top_gear      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.motor_pulse <= (state_d.phase != PH_IDLE);
			res_s2.motor_dir   <= state_d.dir;
			res_s2.busy_res    <= (state_d.phase != PH_IDLE);
			res_s2.done_res    <= done;
			res_s2.rejected    <= rej;
			res_s2.gear_now    <= gear_d;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_req   = res_s2;

	// ---- checks ----
	`ASSERT_CLK(a_rej_needs_done, clk, arst_n, res_valid_s2 |-> (!res_s2.rejected || res_s2.done_res), "rejected without done")
	`ASSERT_CLK(a_done_not_busy, clk, arst_n, res_valid_s2 && res_s2.done_res |-> !res_s2.busy_res, "busy after a finished request")
	`ASSERT_CLK(a_idle_tries, clk, arst_n, state_q.phase == PH_IDLE |-> state_q.tries == TRIES_FIRST, "idle with tries not reset")
	`ASSERT_NEVER(a_active_timer, clk, arst_n, state_q.phase != PH_IDLE && state_q.timer == 8'd0, "pulse with empty timer")
	`ASSERT_CLK(a_stall_full, clk, arst_n, in_stall |-> in_valid_s1 && res_valid_s2, "stall with a free stage")

endmodule
`default_nettype wire

### test/tb_paddle_gear_shift_sequencer.sv
// Testbench of the paddle gear shift sequencer: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb_paddle_gear_shift_sequencer;
	import psq_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 4_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_req;
	logic out_valid;
	logic out_stall;
	out_item_t out_req;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	always #2 clk = ~clk;

	paddle_gear_shift_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies held by the predictor
	logic [15:0] c_rpm_limit;
	logic [7:0]  c_up_ticks, c_down_ticks, c_neutral_ticks;
	logic [2:0]  c_max_tries;
	logic [3:0]  c_top_gear;

	// predicted sequencer state
	logic [7:0]  m_gear;
	logic [15:0] m_speed;
	phase_t      m_phase;
	kind_t       m_kind;
	logic [7:0]  m_timer;
	logic [2:0]  m_try;
	logic [7:0]  m_gear_start;
	logic        m_dir;

	out_item_t shift_results_q[$];
	out_item_t exp_r;
	int n_mismatch = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_settings = 0;
	bit quiet = 1'b0;
	bit burst_in = 1'b0;
	int hold_cycles = 0;

	// ---------------- predictor ----------------
	function automatic void reset_predictor();
		c_rpm_limit = RPM_LIMIT_RST;
		c_up_ticks = UP_TICKS_RST;
		c_down_ticks = DOWN_TICKS_RST;
		c_neutral_ticks = NEUTRAL_TICKS_RST;
		c_max_tries = MAX_TRIES_RST;
		c_top_gear = TOP_GEAR_RST;
		m_gear = '0;
		m_speed = '0;
		m_phase = PH_IDLE;
		m_kind = KIND_NONE;
		m_timer = '0;
		m_try = TRIES_FIRST;
		m_gear_start = '0;
		m_dir = DIR_DOWN;
	endfunction

	// a zero length still drives the motor for one tick
	function automatic void arm_motor(logic [7:0] ticks, logic dir, phase_t ph);
		m_timer = (ticks == 8'd0) ? 8'd1 : ticks;
		m_dir = dir;
		m_phase = ph;
	endfunction

	function automatic status_t begin_upshift();
		m_gear_start = m_gear;
		arm_motor(c_up_ticks, DIR_UP, PH_PULSE);
		return ST_RUN;
	endfunction

	function automatic status_t begin_downshift();
		m_gear_start = m_gear;
		if (m_speed >= c_rpm_limit)
			return ST_FAIL;
		arm_motor(c_down_ticks, DIR_DOWN, PH_PULSE);
		return ST_RUN;
	endfunction

	// neutral search: step down above second, then a half pulse
	function automatic status_t neutral_stage();
		if (m_gear > GEAR_SECOND)
			return begin_downshift();
		m_gear_start = m_gear;
		if (m_gear == GEAR_SECOND) begin
			arm_motor(c_neutral_ticks, DIR_DOWN, PH_HALF);
			return ST_RUN;
		end
		if (m_gear == GEAR_FIRST) begin
			arm_motor(c_neutral_ticks, DIR_UP, PH_HALF);
			return ST_RUN;
		end
		return ST_OK;
	endfunction

	function automatic status_t retry_request();
		if (m_kind == KIND_UP)
			return begin_upshift();
		if (m_kind == KIND_DOWN)
			return begin_downshift();
		return neutral_stage();
	endfunction

	function automatic status_t pulse_finished();
		logic half;
		half = (m_phase == PH_HALF);
		m_phase = PH_IDLE;
		if (m_gear != m_gear_start) begin
			if (m_kind == KIND_NEUTRAL && !half)
				return neutral_stage();
			return ST_OK;
		end
		if (m_gear_start == {4'd0, c_top_gear})
			return ST_FAIL;
		if (m_try < c_max_tries) begin
			m_try = m_try + 3'd1;
			return retry_request();
		end
		return ST_FAIL;
	endfunction

	function automatic out_item_t sequencer_step(in_item_t it);
		status_t st;
		logic active;
		logic done;
		out_item_t r;
		st = ST_RUN;
		active = 1'b0;
		case (it.opcode)
			OP_TICK: begin
				if (m_phase != PH_IDLE) begin
					active = 1'b1;
					if (m_timer != 8'd0)
						m_timer = m_timer - 8'd1;
					if (m_timer == 8'd0)
						st = pulse_finished();
				end
			end
			OP_PADDLE: begin
				if (m_phase == PH_IDLE && (it.up_changed || it.down_changed)) begin
					m_try = TRIES_FIRST;
					if (it.up_fell && it.down_fell) begin
						active = 1'b1;
						m_kind = KIND_NEUTRAL;
						st = neutral_stage();
					end else if (it.up_fell && !it.down_changed) begin
						active = 1'b1;
						m_kind = KIND_UP;
						st = begin_upshift();
					end else if (!it.up_changed && it.down_fell) begin
						active = 1'b1;
						m_kind = KIND_DOWN;
						st = begin_downshift();
					end
				end
			end
			OP_FRAME: begin
				if (it.frame_id == ID_SPEED)
					m_speed = it.frame_data[15:0];
				else if (it.frame_id == ID_GEAR)
					m_gear = it.frame_data[15:8];
			end
			default: ;
		endcase
		done = active && (st != ST_RUN);
		if (done) begin
			m_phase = PH_IDLE;
			m_kind = KIND_NONE;
			m_timer = '0;
			m_try = TRIES_FIRST;
		end
		r.motor_pulse = (m_phase != PH_IDLE);
		r.motor_dir = m_dir;
		r.busy_res = (m_phase != PH_IDLE);
		r.done_res = done;
		r.rejected = done && (st == ST_FAIL);
		r.gear_now = m_gear;
		return r;
	endfunction

	// ---------------- request builders ----------------
	function automatic in_item_t base_req();
		in_item_t it;
		it.opcode = 2'($urandom_range(0, 3));
		it.up_fell = 1'($urandom_range(0, 1));
		it.up_changed = 1'($urandom_range(0, 1));
		it.down_fell = 1'($urandom_range(0, 1));
		it.down_changed = 1'($urandom_range(0, 1));
		it.frame_id = 11'($urandom_range(0, 2047));
		it.frame_data = {$urandom, $urandom};
		return it;
	endfunction

	function automatic in_item_t tick_req();
		in_item_t it;
		it = base_req();
		it.opcode = OP_TICK;
		return it;
	endfunction

	function automatic in_item_t frame_req(logic [10:0] id, logic [63:0] data);
		in_item_t it;
		it = base_req();
		it.opcode = OP_FRAME;
		it.frame_id = id;
		it.frame_data = data;
		return it;
	endfunction

	function automatic in_item_t gear_req(logic [7:0] g);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[15:8] = g;
		return frame_req(ID_GEAR, d);
	endfunction

	function automatic in_item_t speed_req(logic [15:0] s);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[15:0] = s;
		return frame_req(ID_SPEED, d);
	endfunction

	function automatic in_item_t paddle_req(logic uf, logic uc, logic df, logic dc);
		in_item_t it;
		it = base_req();
		it.opcode = OP_PADDLE;
		it.up_fell = uf;
		it.up_changed = uc;
		it.down_fell = df;
		it.down_changed = dc;
		return it;
	endfunction

	function automatic in_item_t paddle_kind_req(kind_t k);
		logic [1:0] ch;
		ch = 2'($urandom_range(1, 3));
		case (k)
			KIND_UP:   return paddle_req(1'b1, 1'b1, 1'b0, 1'b0);
			KIND_DOWN: return paddle_req(1'b0, 1'b0, 1'b1, 1'b1);
			default:   return paddle_req(1'b1, ch[1], 1'b1, ch[0]);
		endcase
	endfunction

	// anything at all, often aimed at the two decoded frame ids
	function automatic in_item_t noise_req();
		in_item_t it;
		int r;
		it = base_req();
		r = $urandom_range(0, 3);
		if (r == 0)
			it.frame_id = ID_SPEED;
		else if (r == 1)
			it.frame_id = ID_GEAR;
		return it;
	endfunction

	function automatic logic [7:0] pick_gear();
		int r;
		int t;
		r = $urandom_range(0, 9);
		t = int'(c_top_gear) + int'($urandom_range(0, 2)) - 1;
		if (r < 6)
			return 8'($urandom_range(0, 8));
		if (r < 8)
			return t[7:0];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_speed();
		if ($urandom_range(0, 1) == 1 && c_rpm_limit != 16'd0)
			return 16'($urandom_range(0, int'(c_rpm_limit) - 1));
		return 16'($urandom_range(int'(c_rpm_limit), 65535));
	endfunction

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------- drivers ----------------
	task automatic send_req(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_req <= it;
		do @(posedge clk); while (in_stall);
		shift_results_q.push_back(sequencer_step(it));
		n_sent++;
		gap = (quiet || burst_in) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_idle();
		in_valid <= 1'b0;
		while (shift_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(logic [15:0] rpm, logic [7:0] up, logic [7:0] down,
			logic [7:0] neu, logic [2:0] tries, logic [3:0] top);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		idx = '{CFG_RPM_LIMIT, CFG_UP_TICKS, CFG_DOWN_TICKS, CFG_NEUTRAL_TICKS,
			CFG_MAX_TRIES, CFG_TOP_GEAR};
		val = '{rpm, {8'd0, up}, {8'd0, down}, {8'd0, neu}, {13'd0, tries}, {12'd0, top}};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		c_rpm_limit = rpm;
		c_up_ticks = up;
		c_down_ticks = down;
		c_neutral_ticks = neu;
		c_max_tries = tries;
		c_top_gear = top;
		n_settings++;
	endtask

	// one paddle request carried to its end, with frames arriving meanwhile
	task automatic shift_sequence();
		int steps;
		int r;
		logic [7:0] g;
		quiet = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 1) == 1)
			send_req(gear_req(pick_gear()));
		if ($urandom_range(0, 2) == 0)
			send_req(speed_req(pick_speed()));
		send_req(paddle_kind_req(kind_t'(2'($urandom_range(1, 3)))));
		steps = 0;
		while (m_phase != PH_IDLE) begin
			steps++;
			r = $urandom_range(0, 99);
			if (r < 72 || steps > 600) begin
				send_req(tick_req());
			end else if (r < 87) begin
				// hold the gear, move it the way the motor drives, or jump
				r = $urandom_range(0, 4);
				if (r < 2)
					g = m_gear_start;
				else if (r < 4)
					g = (m_dir == DIR_UP) ? m_gear + 8'd1 : m_gear - 8'd1;
				else
					g = pick_gear();
				send_req(gear_req(g));
			end else if (r < 92) begin
				send_req(speed_req(pick_speed()));
			end else begin
				send_req(noise_req());
			end
		end
		quiet = 1'b0;
	endtask

	task automatic run_random(int n_items);
		int target;
		target = n_sent + n_items;
		while (n_sent < target) begin
			if ($urandom_range(0, 9) < 2)
				send_req(noise_req());
			else
				shift_sequence();
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_default_registers();
		run_random(150);
	endtask

	task automatic test_directed();
		in_item_t op3;
		op3 = '1;
		wait_results_idle();
		apply_config(16'd1000, 8'd2, 8'd1, 8'd0, 3'd2, 4'd6);
		send_req(tick_req());                          // tick while idle
		send_req(op3);                                 // unused opcode
		send_req(frame_req(11'h7FF, '1));              // unknown frame id
		send_req(frame_req(ID_SPEED, '1));             // speed at maximum
		send_req(paddle_req(1'b0, 1'b0, 1'b1, 1'b1));  // downshift at speed
		send_req(gear_req(8'd5));
		send_req(paddle_req(1'b1, 1'b1, 1'b1, 1'b0));  // neutral, step-down refused
		send_req(frame_req(ID_SPEED, '0));
		send_req(gear_req(8'd3));
		send_req(paddle_req(1'b1, 1'b1, 1'b0, 1'b0));  // upshift
		send_req(paddle_req(1'b0, 1'b0, 1'b1, 1'b1));  // paddle while busy
		send_req(tick_req());
		send_req(gear_req(8'd4));                      // frame while busy
		send_req(tick_req());
		send_req(paddle_req(1'b1, 1'b1, 1'b1, 1'b0));  // neutral from fourth
		send_req(gear_req(8'd2));
		send_req(tick_req());                          // on to the half pulse
		send_req(tick_req());                          // unchanged, retried
		send_req(gear_req(8'd1));
		send_req(tick_req());
		send_req(gear_req(8'd0));
		send_req(paddle_req(1'b1, 1'b0, 1'b1, 1'b1));  // neutral already in gear 0
		send_req(gear_req(8'd6));
		send_req(paddle_req(1'b1, 1'b1, 1'b0, 1'b0));
		send_req(tick_req());
		send_req(tick_req());                          // top gear, no retry
		send_req(paddle_req(1'b1, 1'b0, 1'b1, 1'b0));  // no change flag: ignored
	endtask

	task automatic test_register_extremes();
		wait_results_idle();
		apply_config(16'd0, 8'd1, 8'd1, 8'd1, 3'd1, 4'd1);
		run_random(200);
		wait_results_idle();
		apply_config(16'hFFFF, 8'd0, 8'd0, 8'd0, 3'd7, 4'd15);
		run_random(200);
	endtask

	task automatic test_random_registers();
		repeat (2) begin
			wait_results_idle();
			apply_config(16'($urandom_range(300, 9000)), 8'($urandom_range(1, 6)),
				8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
				3'($urandom_range(1, 7)), 4'($urandom_range(1, 15)));
			run_random(200);
		end
	endtask

	task automatic test_long_pulses();
		wait_results_idle();
		apply_config(16'd3000, 8'd255, 8'd255, 8'd255, 3'd1, 4'($urandom_range(1, 15)));
		run_random(300);
	endtask

	task automatic test_input_backpressure();
		wait_results_idle();
		apply_config(16'd4000, 8'd3, 8'd2, 8'd2, 3'd4, 4'd6);
		// results held back while requests keep coming
		burst_in = 1'b1;
		hold_cycles = 200;
		run_random(60);
		burst_in = 1'b0;
		wait_results_idle();
		run_random(100);
	endtask

	// ---------------- result side ----------------
	initial begin : result_stall_gen
		int stall_left;
		int free_left;
		out_stall = 1'b0;
		stall_left = 0;
		free_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (free_left > 0) begin
					free_left--;
				end else begin
					stall_left = idle_len();
					free_left = $urandom_range(0, 12);
				end
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			n_mismatch++;
		end
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (shift_results_q.size() == 0) begin
				$display("%0t: result with none predicted, got %h", $time, out_req);
				n_mismatch++;
			end else begin
				exp_r = shift_results_q.pop_front();
				check_field("motor_pulse", {7'd0, exp_r.motor_pulse},
					{7'd0, out_req.motor_pulse});
				check_field("motor_dir", {7'd0, exp_r.motor_dir}, {7'd0, out_req.motor_dir});
				check_field("busy_res", {7'd0, exp_r.busy_res}, {7'd0, out_req.busy_res});
				check_field("done_res", {7'd0, exp_r.done_res}, {7'd0, out_req.done_res});
				check_field("rejected", {7'd0, exp_r.rejected}, {7'd0, out_req.rejected});
				check_field("gear_now", exp_r.gear_now, out_req.gear_now);
				n_checked++;
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d results outstanding", shift_results_q.size());
		$display("end of test: mismatches");
		$finish;
	end

	// ---------------- sequence of tests ----------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_registers();
		test_directed();
		test_register_extremes();
		test_random_registers();
		test_long_pulses();
		test_input_backpressure();
		wait_results_idle();
		$display("sent %0d requests under %0d register settings after the reset values",
			n_sent, n_settings);
		$display("checked %0d results, %0d mismatches, %0d left over",
			n_checked, n_mismatch, shift_results_q.size());
		if (n_mismatch == 0 && shift_results_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/psq_pkg.sv
rtl/paddle_gear_shift_sequencer.sv
test/tb_paddle_gear_shift_sequencer.sv
